>>> rtl/urs_pkg.sv
// Shared constants for the ultrasonic ranging sequencer.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package urs_pkg;

  localparam int unsigned SONAR_NUM  = 2;
  localparam int unsigned SONAR_W    = (SONAR_NUM > 1) ? $clog2(SONAR_NUM) : 1;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned DIST_SHIFT = 2;  // width / 4

  localparam logic [TIME_W-1:0] GAP_RESET = 32'd100000;
  localparam logic [DIST_W-1:0] DIST_MAX  = 16'hFFFF;

  localparam logic [SONAR_W-1:0] LAST_SONAR = SONAR_W'(SONAR_NUM - 1);

endpackage

`default_nettype wire

>>> rtl/urs_channels.sv
// Valid/ready channel interfaces for the ranging sequencer core.
// Depends on urs_pkg for field widths.
`default_nettype none

interface urs_tick_if;
  logic                           valid;
  logic                           ready;
  logic [urs_pkg::TIME_W-1:0]     now_us;
  logic [urs_pkg::SONAR_NUM-1:0]  echo_levels;

  modport source (output valid, output now_us, output echo_levels, input ready);
  modport sink   (input valid, input now_us, input echo_levels, output ready);
endinterface

interface urs_reading_if;
  logic                           valid;
  logic                           ready;
  logic [urs_pkg::SONAR_NUM-1:0]  trigger_lines;
  logic                           reading_valid;
  logic [urs_pkg::SONAR_W-1:0]    reading_sonar;
  logic [urs_pkg::DIST_W-1:0]     reading_distance;

  modport source (output valid, output trigger_lines, output reading_valid,
                  output reading_sonar, output reading_distance, input ready);
  modport sink   (input valid, input trigger_lines, input reading_valid,
                  input reading_sonar, input reading_distance, output ready);
endinterface

`default_nettype wire

>>> rtl/ultrasonic_ranging_sequencer_core.sv
// Ultrasonic ranging sequencer: round-robin trigger/echo timing of the sonars.
// Depends on urs_pkg and the channel interfaces in urs_channels.sv.
//
// Usage:
//   tick    : one polling tick per transaction (now_us, echo_levels).
//   reading : exactly one result per tick: trigger line drive after the tick,
//             and, when reading_valid is set, the finished distance (echo
//             width in us / 4, saturated) with its sonar index.
//   cfg     : cfg_wr_en/cfg_wr_data write repeat_gap_us (reset 100000).
// An accepted tick's result is registered and shows in the cycle after the tick is taken.
// Throughput is one tick per cycle while the receiver takes each result; the
// sequencer state and the result register both update in the accepting cycle,
// limited only by the 32-bit time subtract and compare ahead of the result register.
// The result register doubles as the output stage: a tick is accepted
// whenever that register is empty or being drained, so a stalled receiver
// holds the pending result and back-pressures the tick channel.
// Reset puts the sequencer in idle on sonar 0 with mark time 0, the trigger
// drive cleared and the output register empty.
`default_nettype none

module ultrasonic_ranging_sequencer_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [urs_pkg::TIME_W-1:0]  cfg_wr_data,
  urs_tick_if.sink                         tick,
  urs_reading_if.source                    reading
);

  typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_ECHO} main_phase_t;
  typedef enum logic [1:0] {SUB_IDLE, SUB_UP, SUB_DOWN} sub_phase_t;

  main_phase_t                    main_phase, main_phase_next;
  sub_phase_t                     sub_phase, sub_phase_next;
  logic [urs_pkg::TIME_W-1:0]     repeat_gap_us;
  logic [urs_pkg::TIME_W-1:0]     mark_time, mark_time_next;
  logic [urs_pkg::DIST_W-1:0]     pending_distance, pending_distance_next;
  logic [urs_pkg::SONAR_W-1:0]    current_sonar, current_sonar_next;
  logic [urs_pkg::SONAR_NUM-1:0]  trigger_drive, trigger_drive_next;

  logic                           out_valid;
  logic [urs_pkg::SONAR_NUM-1:0]  out_trigger;
  logic                           out_rvalid;
  logic [urs_pkg::SONAR_W-1:0]    out_sonar;
  logic [urs_pkg::DIST_W-1:0]     out_dist;

  logic                           rvalid_next;
  logic [urs_pkg::SONAR_W-1:0]    rsonar_next;
  logic [urs_pkg::DIST_W-1:0]     rdist_next;

  logic                           accept;
  logic [urs_pkg::SONAR_NUM-1:0]  sonar_bit;
  logic                           echo_high;
  logic [urs_pkg::TIME_W-1:0]     elapsed;
  logic [urs_pkg::TIME_W-1:0]     quarter;

  assign tick.ready = !out_valid || reading.ready;
  assign accept     = tick.valid && tick.ready;

  assign sonar_bit = urs_pkg::SONAR_NUM'(1) << current_sonar;
  assign echo_high = |(tick.echo_levels & sonar_bit);
  assign elapsed   = tick.now_us - mark_time;
  assign quarter   = elapsed >> urs_pkg::DIST_SHIFT;

  always_comb begin
    main_phase_next       = main_phase;
    sub_phase_next        = sub_phase;
    mark_time_next        = mark_time;
    pending_distance_next = pending_distance;
    current_sonar_next    = current_sonar;
    trigger_drive_next    = trigger_drive;
    rvalid_next           = 1'b0;
    rsonar_next           = '0;
    rdist_next            = '0;
    unique case (main_phase)
      PH_IDLE: begin
        if (elapsed > repeat_gap_us) main_phase_next = PH_TRIG;
      end
      PH_TRIG: begin
        unique case (sub_phase)
          SUB_IDLE: sub_phase_next = SUB_UP;
          SUB_UP: begin
            trigger_drive_next = trigger_drive | sonar_bit;
            mark_time_next     = tick.now_us;
            sub_phase_next     = SUB_DOWN;
          end
          default: begin
            // hold the line high until the microsecond count moves
            if (tick.now_us != mark_time) begin
              trigger_drive_next = trigger_drive & ~sonar_bit;
              sub_phase_next     = SUB_IDLE;
              main_phase_next    = PH_ECHO;
            end
          end
        endcase
      end
      default: begin
        unique case (sub_phase)
          SUB_IDLE: begin
            if (echo_high) begin
              mark_time_next = tick.now_us;
              sub_phase_next = SUB_UP;
            end
          end
          SUB_UP: begin
            if (!echo_high) begin
              // saturate when any bit above the distance field is set
              if (|quarter[urs_pkg::TIME_W-1:urs_pkg::DIST_W]) begin
                pending_distance_next = urs_pkg::DIST_MAX;
              end else begin
                pending_distance_next = quarter[urs_pkg::DIST_W-1:0];
              end
              sub_phase_next = SUB_DOWN;
            end
          end
          default: begin
            sub_phase_next  = SUB_IDLE;
            main_phase_next = PH_IDLE;
            rvalid_next     = 1'b1;
            rsonar_next     = current_sonar;
            rdist_next      = pending_distance;
            if (current_sonar >= urs_pkg::LAST_SONAR) begin
              current_sonar_next = '0;
            end else begin
              current_sonar_next = current_sonar + 1'b1;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_gap_us    <= urs_pkg::GAP_RESET;
      main_phase       <= PH_IDLE;
      sub_phase        <= SUB_IDLE;
      mark_time        <= '0;
      pending_distance <= '0;
      current_sonar    <= '0;
      trigger_drive    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr_en) repeat_gap_us <= cfg_wr_data;
      if (accept) begin
        main_phase       <= main_phase_next;
        sub_phase        <= sub_phase_next;
        mark_time        <= mark_time_next;
        pending_distance <= pending_distance_next;
        current_sonar    <= current_sonar_next;
        trigger_drive    <= trigger_drive_next;
        out_valid        <= 1'b1;
      end else if (reading.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload: load on every accepted transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      out_trigger <= trigger_drive_next;
      out_rvalid  <= rvalid_next;
      out_sonar   <= rsonar_next;
      out_dist    <= rdist_next;
    end
  end

  assign reading.valid            = out_valid;
  assign reading.trigger_lines    = out_trigger;
  assign reading.reading_valid    = out_rvalid;
  assign reading.reading_sonar    = out_sonar;
  assign reading.reading_distance = out_dist;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> reading.valid)
    else $error("accepted tick produced no result");

  a_one_trigger: assert property (@(posedge clk) disable iff (rst)
    reading.valid |-> $onehot0(reading.trigger_lines))
    else $error("more than one trigger line driven");

  a_trigger_phase: assert property (@(posedge clk) disable iff (rst)
    (trigger_drive != '0) |-> (main_phase == PH_TRIG && sub_phase == SUB_DOWN))
    else $error("trigger driven outside the trigger pulse");

  a_reading_clear: assert property (@(posedge clk) disable iff (rst)
    (reading.valid && !reading.reading_valid) |->
      (reading.reading_distance == '0 && reading.reading_sonar == '0))
    else $error("reading fields set without a reading");

  a_reading_ends_echo: assert property (@(posedge clk) disable iff (rst)
    (accept && rvalid_next) |=> (main_phase == PH_IDLE && sub_phase == SUB_IDLE))
    else $error("sequencer not idle after a reading");

endmodule

`default_nettype wire
